/* hw/rtl/cpe_pkg.sv */
// Shared types, constants and microcode program of the partition enumerator.
package cpe_pkg;

    localparam int DEF_MAX_FUNCTIONS = 8;
    localparam int DEF_MAX_GROUPS    = 8;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 3;
    localparam int VAL_W      = 6;
    localparam int CHOICE_W   = 4;
    localparam int CFG_W      = 4;
    localparam int PART_W     = 24;
    localparam int PART_SEL_W = 3;
    localparam int PART_FUNCS = 8;
    localparam int PTS_W      = 48;
    localparam int TOT_W      = 63;
    localparam int CNT_W      = 25;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int STEP_W     = 5;

    localparam logic [CHOICE_W-1:0] NO_CHOICE = 4'd15;
    localparam logic [PTS_W-1:0]    PTS_MAX   = '1;
    localparam logic [TOT_W-1:0]    TOT_MAX   = '1;
    localparam logic [CNT_W-1:0]    CNT_MAX   = '1;

    localparam logic REG_NUM_FUNCTIONS = 1'b0;
    localparam logic REG_NUM_GROUPS    = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_DEGREE   = 2'd0,
        OP_WRITE_CAPACITY = 2'd1,
        OP_RESTART        = 2'd2,
        OP_FIND_NEXT      = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        A_NONE,
        A_LATCH,
        A_EMIT,
        A_WR_DEG,
        A_WR_CAP,
        A_RESTART,
        A_LOAD_ROW,
        A_SCAN_RD,
        A_COL_INC,
        A_TAKE,
        A_ROW_INC,
        A_CLR_CHOICE,
        A_ROW_DEC,
        A_SET_DONE,
        A_PROD_INIT,
        A_PROD_RD,
        A_PROD_MUL,
        A_ACCUM
    } act_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_CMD,
        C_DISPATCH,
        C_DONE,
        C_COL_END,
        C_NO_HIT,
        C_LAST_ROW,
        C_ROW_ZERO,
        C_K_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [STEP_W-1:0] {
        S_EMIT      = 5'd0,
        S_IDLE      = 5'd1,
        S_DISPATCH  = 5'd2,
        S_OP_WDEG   = 5'd3,
        S_OP_WCAP   = 5'd4,
        S_OP_RST    = 5'd5,
        S_OP_FIND   = 5'd6,
        S_FETCH     = 5'd7,
        S_SCAN_ADDR = 5'd8,
        S_SCAN_TEST = 5'd9,
        S_TAKE      = 5'd10,
        S_ADVANCE   = 5'd11,
        S_FAIL      = 5'd12,
        S_ROW_DEC   = 5'd13,
        S_SET_DONE  = 5'd14,
        S_PROD_INIT = 5'd15,
        S_PROD_RD   = 5'd16,
        S_PROD_MUL  = 5'd17,
        S_ACCUM     = 5'd18
    } step_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        act_t act;
    } ctrl_t;

    typedef struct packed {
        logic no_cmd;
        op_t  op;
        logic done;
        logic col_end;
        logic hit;
        logic last_row;
        logic row_zero;
        logic k_more;
        logic out_busy;
    } status_t;

    // taken condition jumps to target (dispatch jumps by opcode instead), otherwise fall through to the next step
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        unique case (step)
            S_EMIT:      w = '{A_EMIT,       C_OUT_BUSY, S_EMIT};
            S_IDLE:      w = '{A_LATCH,      C_NO_CMD,   S_IDLE};
            S_DISPATCH:  w = '{A_NONE,       C_DISPATCH, S_IDLE};
            S_OP_WDEG:   w = '{A_WR_DEG,     C_ALWAYS,   S_EMIT};
            S_OP_WCAP:   w = '{A_WR_CAP,     C_ALWAYS,   S_EMIT};
            S_OP_RST:    w = '{A_RESTART,    C_ALWAYS,   S_EMIT};
            S_OP_FIND:   w = '{A_NONE,       C_DONE,     S_EMIT};
            S_FETCH:     w = '{A_LOAD_ROW,   C_NEVER,    S_IDLE};
            S_SCAN_ADDR: w = '{A_SCAN_RD,    C_COL_END,  S_FAIL};
            S_SCAN_TEST: w = '{A_COL_INC,    C_NO_HIT,   S_SCAN_ADDR};
            S_TAKE:      w = '{A_TAKE,       C_LAST_ROW, S_PROD_INIT};
            S_ADVANCE:   w = '{A_ROW_INC,    C_ALWAYS,   S_FETCH};
            S_FAIL:      w = '{A_CLR_CHOICE, C_ROW_ZERO, S_SET_DONE};
            S_ROW_DEC:   w = '{A_ROW_DEC,    C_ALWAYS,   S_FETCH};
            S_SET_DONE:  w = '{A_SET_DONE,   C_ALWAYS,   S_EMIT};
            S_PROD_INIT: w = '{A_PROD_INIT,  C_NEVER,    S_IDLE};
            S_PROD_RD:   w = '{A_PROD_RD,    C_NEVER,    S_IDLE};
            S_PROD_MUL:  w = '{A_PROD_MUL,   C_K_MORE,   S_PROD_RD};
            S_ACCUM:     w = '{A_ACCUM,      C_ALWAYS,   S_EMIT};
            default:     w = '{A_NONE,       C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

    function automatic step_t dispatch_step(input op_t op);
        step_t s;
        unique case (op)
            OP_WRITE_DEGREE:   s = S_OP_WDEG;
            OP_WRITE_CAPACITY: s = S_OP_WCAP;
            OP_RESTART:        s = S_OP_RST;
            OP_FIND_NEXT:      s = S_OP_FIND;
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/cpe_ifs.sv */
// Command and result stream interfaces of the partition enumerator.
interface cpe_cmd_if import cpe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] column_index;
    logic [VAL_W-1:0] value;

    modport source (output valid, output operation, output row_index,
                    output column_index, output value, input ready);
    modport sink   (input valid, input operation, input row_index,
                    input column_index, input value, output ready);
endinterface

interface cpe_rsp_if import cpe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PART_W-1:0] partition;
    logic [PTS_W-1:0]  points;
    logic [TOT_W-1:0]  total_points;
    logic [CNT_W-1:0]  partitions_found;
    logic              found;
    logic              exhausted;

    modport source (output valid, output partition, output points, output total_points,
                    output partitions_found, output found, output exhausted,
                    input ready);
    modport sink   (input valid, input partition, input points, input total_points,
                    input partitions_found, input found, input exhausted,
                    output ready);
endinterface

/* hw/rtl/cpe_ram.sv */
// Generic single-port-write RAM with registered read.
module cpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/cpe_sequencer.sv */
// Microcode sequencer: step counter, program ROM and jump conditions.
module cpe_sequencer import cpe_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    step_t      upc_reg;
    step_t      upc_next;
    ctrl_word_t word;
    logic       taken;

    assign word = ucode_rom(upc_reg);

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_CMD:   taken = status.no_cmd;
            C_DISPATCH: taken = 1'b1;
            C_DONE:     taken = status.done;
            C_COL_END:  taken = status.col_end;
            C_NO_HIT:   taken = !status.hit;
            C_LAST_ROW: taken = status.last_row;
            C_ROW_ZERO: taken = status.row_zero;
            C_K_MORE:   taken = status.k_more;
            C_OUT_BUSY: taken = status.out_busy;
            default:    taken = 1'b1;
        endcase
    end

    always_comb
    begin
        if (!taken)
        begin
            upc_next = step_t'(upc_reg + 1'b1);
        end
        else if (word.cond == C_DISPATCH)
        begin
            upc_next = dispatch_step(status.op);
        end
        else
        begin
            upc_next = word.target;
        end
    end

    always_comb
    begin
        ctrl.act = word.act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* hw/rtl/cpe_datapath.sv */
// Datapath: degree table, capacities, choice stack, product and sums, result register.
module cpe_datapath import cpe_pkg::*; #(
    parameter int MAX_FUNCTIONS = DEF_MAX_FUNCTIONS,
    parameter int MAX_GROUPS    = DEF_MAX_GROUPS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] num_functions,
    input  logic [CFG_W-1:0] num_groups,
    input  ctrl_t            ctrl,
    output status_t          status,
    cpe_cmd_if.sink          cmd,
    cpe_rsp_if.source        rsp
);

    localparam int RW     = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
    localparam int GW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int FCW    = $clog2(MAX_FUNCTIONS + 1);
    localparam int GCW    = $clog2(MAX_GROUPS + 1);
    localparam int AW     = (MAX_FUNCTIONS * MAX_GROUPS > 1) ?
                            $clog2(MAX_FUNCTIONS * MAX_GROUPS) : 1;
    localparam int DEPTH  = 1 << AW;
    localparam int PROD_W = PTS_W + VAL_W;
    localparam int SUM_W  = TOT_W + 1;

    op_t               op_reg, op_next;
    logic [IDX_W-1:0]  row_in_reg, row_in_next;
    logic [IDX_W-1:0]  col_in_reg, col_in_next;
    logic [VAL_W-1:0]  val_reg, val_next;

    logic [FCW-1:0]    active_f_reg, active_f_next;
    logic [GCW-1:0]    active_g_reg, active_g_next;
    logic [CHOICE_W-1:0] choice_reg [MAX_FUNCTIONS];
    logic [CHOICE_W-1:0] choice_next [MAX_FUNCTIONS];
    logic [VAL_W-1:0]  remain_reg [MAX_GROUPS];
    logic [VAL_W-1:0]  remain_next [MAX_GROUPS];
    logic [VAL_W-1:0]  cap_reg [MAX_GROUPS];
    logic [VAL_W-1:0]  cap_next [MAX_GROUPS];
    logic [DEPTH-1:0]  deg_valid_reg, deg_valid_next;

    logic [RW-1:0]     r_reg, r_next;
    logic [RW-1:0]     k_reg, k_next;
    logic [GCW-1:0]    col_reg, col_next;
    logic [GW-1:0]     rd_col_reg, rd_col_next;
    logic              dv_reg, dv_next;
    logic [PART_W-1:0] part_reg, part_next;
    logic [PTS_W-1:0]  pts_reg, pts_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;

    logic              out_valid_reg, out_valid_next;
    logic [PART_W-1:0] out_part_reg, out_part_next;
    logic [PTS_W-1:0]  out_pts_reg, out_pts_next;
    logic [TOT_W-1:0]  out_total_reg, out_total_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic              out_found_reg, out_found_next;
    logic              out_exh_reg, out_exh_next;

    logic              wr_in_range;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     scan_addr;
    logic [AW-1:0]     prod_addr;
    logic [AW-1:0]     raddr;
    logic [VAL_W-1:0]  deg_rdata;
    logic [VAL_W-1:0]  deg_eff;
    logic [CHOICE_W-1:0] cur_choice;
    logic [CHOICE_W-1:0] k_choice;
    logic [RW-1:0]     r_inc;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic              hit;
    logic              out_busy;
    logic              emit;
    logic [FCW-1:0]    af_clamped;
    logic [GCW-1:0]    ag_clamped;

    assign wr_in_range = (int'(row_in_reg) < MAX_FUNCTIONS) && (int'(col_in_reg) < MAX_GROUPS);
    assign wr_addr     = AW'(int'(row_in_reg) * MAX_GROUPS + int'(col_in_reg));
    assign cur_choice  = choice_reg[r_reg];
    assign k_choice    = choice_reg[k_reg];
    assign r_inc       = r_reg + 1'b1;
    assign scan_addr   = AW'(int'(r_reg) * MAX_GROUPS + int'(col_reg));
    assign prod_addr   = AW'(int'(k_reg) * MAX_GROUPS + int'(k_choice));
    assign raddr       = (ctrl.act == A_PROD_RD) ? prod_addr : scan_addr;
    assign deg_eff     = dv_reg ? deg_rdata : '0;
    assign hit         = (deg_eff != '0) && (remain_reg[rd_col_reg] != '0);
    assign prod        = PROD_W'(pts_reg) * PROD_W'(deg_eff);
    assign sum         = SUM_W'(total_reg) + SUM_W'(pts_reg);
    assign out_busy    = out_valid_reg && !rsp.ready;
    assign emit        = (ctrl.act == A_EMIT) && !out_busy;

    always_comb
    begin
        if (num_functions == '0)
        begin
            af_clamped = FCW'(1);
        end
        else if (int'(num_functions) > MAX_FUNCTIONS)
        begin
            af_clamped = FCW'(MAX_FUNCTIONS);
        end
        else
        begin
            af_clamped = FCW'(num_functions);
        end
        if (num_groups == '0)
        begin
            ag_clamped = GCW'(1);
        end
        else if (int'(num_groups) > MAX_GROUPS)
        begin
            ag_clamped = GCW'(MAX_GROUPS);
        end
        else
        begin
            ag_clamped = GCW'(num_groups);
        end
    end

    cpe_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_degree_ram (
        .clk   (clk),
        .we    ((ctrl.act == A_WR_DEG) && wr_in_range),
        .waddr (wr_addr),
        .wdata (val_reg),
        .raddr (raddr),
        .rdata (deg_rdata)
    );

    always_comb
    begin
        op_next        = op_reg;
        row_in_next    = row_in_reg;
        col_in_next    = col_in_reg;
        val_next       = val_reg;
        active_f_next  = active_f_reg;
        active_g_next  = active_g_reg;
        choice_next    = choice_reg;
        remain_next    = remain_reg;
        cap_next       = cap_reg;
        deg_valid_next = deg_valid_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        col_next       = col_reg;
        rd_col_next    = rd_col_reg;
        dv_next        = deg_valid_reg[raddr];
        part_next      = part_reg;
        pts_next       = pts_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        found_next     = found_reg;
        out_part_next  = out_part_reg;
        out_pts_next   = out_pts_reg;
        out_total_next = out_total_reg;
        out_count_next = out_count_reg;
        out_found_next = out_found_reg;
        out_exh_next   = out_exh_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (ctrl.act)
            A_LATCH:
            begin
                op_next     = op_t'(cmd.operation);
                row_in_next = cmd.row_index;
                col_in_next = cmd.column_index;
                val_next    = cmd.value;
            end
            A_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_part_next  = found_reg ? part_reg : '0;
                    out_pts_next   = found_reg ? pts_reg : '0;
                    out_total_next = total_reg;
                    out_count_next = count_reg;
                    out_found_next = found_reg;
                    out_exh_next   = done_reg;
                    found_next     = 1'b0;
                end
            end
            A_WR_DEG:
            begin
                if (wr_in_range)
                begin
                    deg_valid_next[wr_addr] = 1'b1;
                end
            end
            A_WR_CAP:
            begin
                for (int i = 0; i < MAX_GROUPS; i++)
                begin
                    if (int'(col_in_reg) == i)
                    begin
                        cap_next[i] = val_reg;
                    end
                end
            end
            A_RESTART:
            begin
                active_f_next = af_clamped;
                active_g_next = ag_clamped;
                remain_next   = cap_reg;
                for (int i = 0; i < MAX_FUNCTIONS; i++)
                begin
                    choice_next[i] = NO_CHOICE;
                end
                r_next     = '0;
                total_next = '0;
                count_next = '0;
                done_next  = 1'b0;
            end
            A_LOAD_ROW:
            begin
                col_next = '0;
                if (cur_choice != NO_CHOICE)
                begin
                    col_next = GCW'(int'(cur_choice) + 1);
                    for (int i = 0; i < MAX_GROUPS; i++)
                    begin
                        if (int'(cur_choice) == i)
                        begin
                            remain_next[i] = remain_reg[i] + 1'b1;
                        end
                    end
                end
            end
            A_SCAN_RD:
            begin
                rd_col_next = col_reg[GW-1:0];
            end
            A_COL_INC:
            begin
                col_next = col_reg + 1'b1;
            end
            A_TAKE:
            begin
                remain_next[rd_col_reg] = remain_reg[rd_col_reg] - 1'b1;
                choice_next[r_reg]      = CHOICE_W'(rd_col_reg);
            end
            A_ROW_INC:
            begin
                r_next             = r_inc;
                choice_next[r_inc] = NO_CHOICE;
            end
            A_CLR_CHOICE:
            begin
                choice_next[r_reg] = NO_CHOICE;
            end
            A_ROW_DEC:
            begin
                r_next = r_reg - 1'b1;
            end
            A_SET_DONE:
            begin
                done_next = 1'b1;
            end
            A_PROD_INIT:
            begin
                k_next    = '0;
                part_next = '0;
                pts_next  = PTS_W'(1);
            end
            A_PROD_RD:
            begin
                if (int'(k_reg) < PART_FUNCS)
                begin
                    part_next = part_reg |
                                (PART_W'(k_choice[PART_SEL_W-1:0]) << (PART_SEL_W * int'(k_reg)));
                end
            end
            A_PROD_MUL:
            begin
                pts_next = (prod[PROD_W-1:PTS_W] != '0) ? PTS_MAX : prod[PTS_W-1:0];
                k_next   = k_reg + 1'b1;
            end
            A_ACCUM:
            begin
                if (count_reg != CNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                total_next = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
                found_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_f_reg  <= FCW'(1);
            active_g_reg  <= GCW'(1);
            for (int i = 0; i < MAX_FUNCTIONS; i++)
            begin
                choice_reg[i] <= NO_CHOICE;
            end
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                remain_reg[i] <= '0;
                cap_reg[i]    <= '0;
            end
            deg_valid_reg <= '0;
            r_reg         <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b1;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_f_reg  <= active_f_next;
            active_g_reg  <= active_g_next;
            choice_reg    <= choice_next;
            remain_reg    <= remain_next;
            cap_reg       <= cap_next;
            deg_valid_reg <= deg_valid_next;
            r_reg         <= r_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        row_in_reg    <= row_in_next;
        col_in_reg    <= col_in_next;
        val_reg       <= val_next;
        k_reg         <= k_next;
        col_reg       <= col_next;
        rd_col_reg    <= rd_col_next;
        dv_reg        <= dv_next;
        part_reg      <= part_next;
        pts_reg       <= pts_next;
        out_part_reg  <= out_part_next;
        out_pts_reg   <= out_pts_next;
        out_total_reg <= out_total_next;
        out_count_reg <= out_count_next;
        out_found_reg <= out_found_next;
        out_exh_reg   <= out_exh_next;
    end

    assign cmd.ready            = (ctrl.act == A_LATCH);
    assign rsp.valid            = out_valid_reg;
    assign rsp.partition        = out_part_reg;
    assign rsp.points           = out_pts_reg;
    assign rsp.total_points     = out_total_reg;
    assign rsp.partitions_found = out_count_reg;
    assign rsp.found            = out_found_reg;
    assign rsp.exhausted        = out_exh_reg;

    assign status.no_cmd   = !cmd.valid;
    assign status.op       = op_reg;
    assign status.done     = done_reg;
    assign status.col_end  = int'(col_reg) >= int'(active_g_reg);
    assign status.hit      = hit;
    assign status.last_row = (int'(r_reg) + 1) >= int'(active_f_reg);
    assign status.row_zero = (r_reg == '0);
    assign status.k_more   = (int'(k_reg) + 1) < int'(active_f_reg);
    assign status.out_busy = out_busy;

endmodule

/* hw/rtl/capacity_partition_enumerator.sv */
// Top level: APB register file, microcode sequencer and enumeration datapath.
// Each command takes one transfer on cmd and yields one transfer on rsp. Degree
// writes, capacity writes, restarts and finds after exhaustion pass dispatch and
// their own step and then load the result. A find-next request runs a microprogram
// over one shared datapath: dispatch, a fetch of the current row, for each column
// tested a registered read of the degree RAM and then the eligibility test, a take
// on a hit, a step down to the next row, or a back-up of one row (end-of-row read,
// clear, decrement, fetch). A complete partition over N functions then takes a
// setup step, one degree read and one 48x6 multiply per function for the product
// of degrees, then sums and result load; running out takes an end-of-row read,
// clear, done flag and result load. The next command is taken once the result
// register is loaded, even if that result has not yet been taken.
// num_functions and num_groups (APB offsets 0x0 and 0x4) are sampled at restart; 0
// counts as 1 and values above the parameter maximum clamp to it.
module capacity_partition_enumerator import cpe_pkg::*; #(
    parameter int MAX_FUNCTIONS = DEF_MAX_FUNCTIONS,
    parameter int MAX_GROUPS    = DEF_MAX_GROUPS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    cpe_cmd_if.sink            cmd,
    cpe_rsp_if.source          rsp
);

    logic [CFG_W-1:0] nf_reg, nf_next;
    logic [CFG_W-1:0] ng_reg, ng_next;
    logic             cfg_wr;
    ctrl_t            ctrl;
    status_t          status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        nf_next = nf_reg;
        ng_next = ng_reg;
        if (cfg_wr)
        begin
            unique case (paddr[PADDR_W-1])
                REG_NUM_FUNCTIONS: nf_next = pwdata[CFG_W-1:0];
                REG_NUM_GROUPS:    ng_next = pwdata[CFG_W-1:0];
                default:           nf_next = nf_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[PADDR_W-1])
            REG_NUM_FUNCTIONS: prdata = PDATA_W'(nf_reg);
            REG_NUM_GROUPS:    prdata = PDATA_W'(ng_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg <= CFG_W'(1);
            ng_reg <= CFG_W'(1);
        end
        else
        begin
            nf_reg <= nf_next;
            ng_reg <= ng_next;
        end
    end

    cpe_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    cpe_datapath #(
        .MAX_FUNCTIONS (MAX_FUNCTIONS),
        .MAX_GROUPS    (MAX_GROUPS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .num_functions (nf_reg),
        .num_groups    (ng_reg),
        .ctrl          (ctrl),
        .status        (status),
        .cmd           (cmd),
        .rsp           (rsp)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for capacity_partition_enumerator: directed vectors, random search phases.
module tb_top;
    import cpe_pkg::*;

    localparam int NF          = DEF_MAX_FUNCTIONS;
    localparam int NG          = DEF_MAX_GROUPS;
    localparam int ITEM_TARGET = 1150;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 20;

    localparam logic [PADDR_W-1:0] FUNCS_ADDR  = {REG_NUM_FUNCTIONS, 2'b00};
    localparam logic [PADDR_W-1:0] GROUPS_ADDR = {REG_NUM_GROUPS, 2'b00};

    typedef struct packed {
        logic [PART_W-1:0] partition;
        logic [PTS_W-1:0]  points;
        logic [TOT_W-1:0]  total_points;
        logic [CNT_W-1:0]  partitions_found;
        logic              found;
        logic              exhausted;
    } outcome_t;

    typedef enum bit {V_ITEM, V_REG} vec_kind_t;

    typedef struct {
        vec_kind_t          kind;
        op_t                op;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VAL_W-1:0]   val;
        logic [PADDR_W-1:0] addr;
        logic [CFG_W-1:0]   data;
        bit                 checked;
        outcome_t           want;
    } vector_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cpe_cmd_if cmd_if();
    cpe_rsp_if rsp_if();

    capacity_partition_enumerator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_if),
        .rsp     (rsp_if)
    );

    always #5 clk = ~clk;

    // search model state
    logic [VAL_W-1:0]    deg_mem [NF][NG];
    logic [VAL_W-1:0]    cap_set [NG];
    logic [VAL_W-1:0]    cap_left [NG];
    logic [CHOICE_W-1:0] pick [NF];
    int                  row_ptr;
    logic [TOT_W-1:0]    pts_sum;
    logic [CNT_W-1:0]    hit_count;
    bit                  walk_done;
    logic [CFG_W-1:0]    reg_funcs;
    logic [CFG_W-1:0]    reg_groups;
    int                  live_funcs;
    int                  live_groups;

    outcome_t pending_q[$];
    vector_t  directed_q[$];

    // travels with the command payload
    bit       vec_checked;
    outcome_t vec_want;

    int errors;
    int items_sent;
    int results_seen;
    int partitions_seen;
    int exhaust_seen;
    int reg_writes;
    int wide_phases;
    int phases;
    int hold_requests;
    int send_calm;
    int cycle_count;

    function automatic int clamp_count(input int v, input int maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void clear_model();
        for (int r = 0; r < NF; r++)
        begin
            pick[r] = NO_CHOICE;
            for (int c = 0; c < NG; c++)
                deg_mem[r][c] = '0;
        end
        for (int c = 0; c < NG; c++)
        begin
            cap_set[c]  = '0;
            cap_left[c] = '0;
        end
        row_ptr     = 0;
        pts_sum     = '0;
        hit_count   = '0;
        walk_done   = 1'b1;
        reg_funcs   = 4'd1;
        reg_groups  = 4'd1;
        live_funcs  = 1;
        live_groups = 1;
    endfunction

    function automatic outcome_t search_status();
        outcome_t o;
        o                  = '0;
        o.total_points     = pts_sum;
        o.partitions_found = hit_count;
        o.exhausted        = walk_done;
        return o;
    endfunction

    function automatic outcome_t next_partition();
        outcome_t          o;
        int                r;
        int                c;
        int                start;
        int                col;
        logic [PART_W-1:0] part;
        longint unsigned   pts;
        longint unsigned   d;
        if (walk_done)
            return search_status();
        while (1'b1)
        begin
            r = (row_ptr >= NF) ? NF - 1 : row_ptr;
            c = pick[r];
            start = 0;
            if (c != NO_CHOICE)
            begin
                start = c + 1;
                if (c < NG)
                    cap_left[c] = cap_left[c] + 1'b1;
            end
            for (col = start; col < live_groups; col++)
                if (deg_mem[r][col] != 0 && cap_left[col] != 0)
                    break;
            if (col >= live_groups)
            begin
                pick[r] = NO_CHOICE;
                if (r == 0)
                begin
                    walk_done = 1'b1;
                    return search_status();
                end
                row_ptr = r - 1;
                continue;
            end
            cap_left[col] = cap_left[col] - 1'b1;
            pick[r] = CHOICE_W'(col);
            if (r + 1 < live_funcs)
            begin
                row_ptr = r + 1;
                pick[r + 1] = NO_CHOICE;
                continue;
            end
            row_ptr = r;
            part = '0;
            pts = 1;
            for (r = 0; r < live_funcs; r++)
            begin
                c = pick[r];
                if (r < PART_FUNCS)
                    part[PART_SEL_W*r +: PART_SEL_W] = c[PART_SEL_W-1:0];
                d = (c < NG) ? deg_mem[r][c] : 0;
                if (d != 0 && pts > PTS_MAX / d)
                    pts = PTS_MAX;
                else
                    pts = pts * d;
            end
            if (hit_count != CNT_MAX)
                hit_count = hit_count + 1'b1;
            if (pts_sum > TOT_MAX - pts)
                pts_sum = TOT_MAX;
            else
                pts_sum = TOT_W'(pts_sum + pts);
            o           = search_status();
            o.partition = part;
            o.points    = pts[PTS_W-1:0];
            o.found     = 1'b1;
            return o;
        end
        return search_status();
    endfunction

    function automatic outcome_t apply_command(input op_t op, input logic [IDX_W-1:0] row,
                                               input logic [IDX_W-1:0] col,
                                               input logic [VAL_W-1:0] val);
        case (op)
            OP_WRITE_DEGREE:
            begin
                deg_mem[row][col] = val;
                return search_status();
            end
            OP_WRITE_CAPACITY:
            begin
                cap_set[col] = val;
                return search_status();
            end
            OP_RESTART:
            begin
                live_funcs  = clamp_count(reg_funcs, NF);
                live_groups = clamp_count(reg_groups, NG);
                for (int c = 0; c < NG; c++)
                    cap_left[c] = cap_set[c];
                for (int r = 0; r < NF; r++)
                    pick[r] = NO_CHOICE;
                row_ptr   = 0;
                pts_sum   = '0;
                hit_count = '0;
                walk_done = 1'b0;
                return search_status();
            end
            default:
                return next_partition();
        endcase
    endfunction

    function automatic outcome_t quiet(input longint unsigned tot, input int cnt, input bit exh);
        outcome_t o;
        o                  = '0;
        o.total_points     = TOT_W'(tot);
        o.partitions_found = CNT_W'(cnt);
        o.exhausted        = exh;
        return o;
    endfunction

    function automatic outcome_t reported(input logic [PART_W-1:0] part,
                                          input longint unsigned pts,
                                          input longint unsigned tot, input int cnt);
        outcome_t o;
        o           = quiet(tot, cnt, 1'b0);
        o.partition = part;
        o.points    = PTS_W'(pts);
        o.found     = 1'b1;
        return o;
    endfunction

    function automatic void add_cmd(input op_t op, input logic [IDX_W-1:0] row,
                                    input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val,
                                    input bit checked = 1'b0, input outcome_t want = '0);
        vector_t v;
        v.kind     = V_ITEM;
        v.op       = op;
        v.row      = row;
        v.col      = col;
        v.val      = val;
        v.addr     = '0;
        v.data     = '0;
        v.checked  = checked;
        v.want     = want;
        directed_q = {directed_q, v};
    endfunction

    function automatic void add_reg(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        vector_t v;
        v.kind     = V_REG;
        v.op       = OP_FIND_NEXT;
        v.row      = '0;
        v.col      = '0;
        v.val      = '0;
        v.addr     = addr;
        v.data     = data;
        v.checked  = 1'b0;
        v.want     = '0;
        directed_q = {directed_q, v};
    endfunction

    function automatic int pick_gap();
        int r;
        if (send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            send_calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic send_item(input op_t op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val,
                             input bit checked = 1'b0, input outcome_t want = '0);
        int gap;
        cmd_if.valid        <= 1'b1;
        cmd_if.operation    <= op;
        cmd_if.row_index    <= row;
        cmd_if.column_index <= col;
        cmd_if.value        <= val;
        vec_checked         <= checked;
        vec_want            <= want;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_q.size() != 0);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_W'(data);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == FUNCS_ADDR)
            reg_funcs = data;
        else
            reg_groups = data;
        reg_writes++;
    endtask

    task automatic build_directed();
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0, 1'b1, quiet(0, 0, 1'b1));
        add_reg(FUNCS_ADDR, 4'd0);
        add_reg(GROUPS_ADDR, 4'd0);
        add_cmd(OP_RESTART, 3'd0, 3'd0, 6'd0, 1'b1, quiet(0, 0, 1'b0));
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0, 1'b1, quiet(0, 0, 1'b1));
        add_cmd(OP_WRITE_DEGREE, 3'd0, 3'd0, 6'd63, 1'b1, quiet(0, 0, 1'b1));
        add_cmd(OP_WRITE_CAPACITY, 3'd0, 3'd0, 6'd63, 1'b1, quiet(0, 0, 1'b1));
        add_cmd(OP_RESTART, 3'd7, 3'd7, 6'd63, 1'b1, quiet(0, 0, 1'b0));
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0, 1'b1, reported(24'h0, 63, 63, 1));
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0, 1'b1, quiet(63, 1, 1'b1));
        add_cmd(OP_FIND_NEXT, 3'd7, 3'd7, 6'd63, 1'b1, quiet(63, 1, 1'b1));
        add_reg(FUNCS_ADDR, 4'd2);
        add_reg(GROUPS_ADDR, 4'd15);
        add_cmd(OP_WRITE_CAPACITY, 3'd0, 3'd7, 6'd63, 1'b1, quiet(63, 1, 1'b1));
        add_cmd(OP_WRITE_DEGREE, 3'd1, 3'd7, 6'd1, 1'b1, quiet(63, 1, 1'b1));
        add_cmd(OP_WRITE_DEGREE, 3'd7, 3'd7, 6'd42, 1'b1, quiet(63, 1, 1'b1));
        add_cmd(OP_WRITE_DEGREE, 3'd0, 3'd5, 6'd21, 1'b1, quiet(63, 1, 1'b1));
        add_cmd(OP_WRITE_CAPACITY, 3'd0, 3'd5, 6'd42, 1'b1, quiet(63, 1, 1'b1));
        add_cmd(OP_RESTART, 3'd0, 3'd0, 6'd0, 1'b1, quiet(0, 0, 1'b0));
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0, 1'b1, reported(24'h38, 63, 63, 1));
        // chosen entry zeroed mid-search
        add_cmd(OP_WRITE_DEGREE, 3'd1, 3'd7, 6'd0, 1'b1, quiet(63, 1, 1'b0));
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0);
        add_cmd(OP_WRITE_CAPACITY, 3'd0, 3'd0, 6'd0);
        add_cmd(OP_WRITE_DEGREE, 3'd1, 3'd7, 6'd63);
        add_cmd(OP_RESTART, 3'd0, 3'd0, 6'd0);
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0);
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0);
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0);
        add_cmd(OP_FIND_NEXT, 3'd0, 3'd0, 6'd0);
    endtask

    task automatic run_phase(input bit force_hold);
        int               nf_reg;
        int               ng_reg;
        int               nf_eff;
        int               ng_eff;
        int               finds;
        int               r;
        bit               wide;
        logic [VAL_W-1:0] v;
        wide = ($urandom_range(0, 9) == 0);
        if (wide)
        begin
            nf_reg = $urandom_range(5, 15);
            ng_reg = $urandom_range(5, 15);
            wide_phases++;
        end
        else
        begin
            nf_reg = $urandom_range(0, 4);
            ng_reg = $urandom_range(0, 4);
        end
        nf_eff = clamp_count(nf_reg, NF);
        ng_eff = clamp_count(ng_reg, NG);
        drain();
        reg_write(FUNCS_ADDR, CFG_W'(nf_reg));
        reg_write(GROUPS_ADDR, CFG_W'(ng_reg));
        for (int row = 0; row < nf_eff; row++)
            for (int col = 0; col < ng_eff; col++)
            begin
                r = $urandom_range(0, 7);
                if (wide)
                    v = VAL_W'($urandom_range(1, 63));
                else if (r < 2)
                    v = '0;
                else if (r == 2)
                    v = '1;
                else
                    v = VAL_W'($urandom_range(1, 62));
                send_item(OP_WRITE_DEGREE, IDX_W'(row), IDX_W'(col), v);
            end
        // wide tables: every degree nonzero and group 0 unbounded, so no dead ends
        for (int col = 0; col < ng_eff; col++)
        begin
            if (wide)
                v = (col == 0) ? 6'd63 : 6'($urandom_range(1, 63));
            else if ($urandom_range(0, 3) == 0)
                v = VAL_W'($urandom_range(0, 63));
            else
                v = VAL_W'($urandom_range(0, nf_eff));
            send_item(OP_WRITE_CAPACITY, IDX_W'($urandom_range(0, 7)), IDX_W'(col), v);
        end
        send_item(OP_RESTART, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                  VAL_W'($urandom_range(0, 63)));
        finds = wide ? $urandom_range(5, 25) : $urandom_range(2, 40);
        for (int k = 0; k < finds; k++)
        begin
            if (k == 2 && (force_hold || $urandom_range(0, 14) == 0))
                hold_requests <= hold_requests + 1;
            if ($urandom_range(0, 9) != 0)
                send_item(OP_FIND_NEXT, IDX_W'($urandom_range(0, 7)),
                          IDX_W'($urandom_range(0, 7)), VAL_W'($urandom_range(0, 63)));
            else if (wide)
                send_item($urandom_range(0, 3) == 0 ? OP_RESTART : OP_WRITE_DEGREE,
                          IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                          VAL_W'($urandom_range(1, 63)));
            else
                send_item(op_t'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 7)),
                          IDX_W'($urandom_range(0, 7)), VAL_W'($urandom_range(0, 63)));
        end
        phases++;
    endtask

    always @(posedge clk)
    begin : scoreboard
        outcome_t got;
        outcome_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.partition        = rsp_if.partition;
                got.points           = rsp_if.points;
                got.total_points     = rsp_if.total_points;
                got.partitions_found = rsp_if.partitions_found;
                got.found            = rsp_if.found;
                got.exhausted        = rsp_if.exhausted;
                results_seen++;
                if (got.found)
                    partitions_seen++;
                else if (got.exhausted)
                    exhaust_seen++;
                if (pending_q.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    check_field("partition", want.partition, got.partition);
                    check_field("points", want.points, got.points);
                    check_field("total_points", want.total_points, got.total_points);
                    check_field("partitions_found", want.partitions_found,
                                got.partitions_found);
                    check_field("found", want.found, got.found);
                    check_field("exhausted", want.exhausted, got.exhausted);
                end
            end
            if (cmd_if.valid && cmd_if.ready)
            begin
                want = apply_command(op_t'(cmd_if.operation), cmd_if.row_index,
                                     cmd_if.column_index, cmd_if.value);
                if (vec_checked)
                    want = vec_want;
                pending_q = {pending_q, want};
            end
        end
    end

    initial
    begin : rsp_side
        int stall_left;
        int calm_left;
        int holds_served;
        int r;
        stall_left   = 0;
        calm_left    = 0;
        holds_served = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        calm_left = $urandom_range(30, 120);
                    else if (r < 30)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 34)
                        stall_left = $urandom_range(15, 50);
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_q.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cmd_if.valid        = 1'b0;
        cmd_if.operation    = '0;
        cmd_if.row_index    = '0;
        cmd_if.column_index = '0;
        cmd_if.value        = '0;
        vec_checked         = 1'b0;
        vec_want            = '0;
        errors              = 0;
        items_sent          = 0;
        results_seen        = 0;
        partitions_seen     = 0;
        exhaust_seen        = 0;
        reg_writes          = 0;
        wide_phases         = 0;
        phases              = 0;
        hold_requests       = 0;
        send_calm           = 0;
        clear_model();
        build_directed();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_q[i])
        begin
            if (directed_q[i].kind == V_REG)
            begin
                drain();
                reg_write(directed_q[i].addr, directed_q[i].data);
            end
            else
                send_item(directed_q[i].op, directed_q[i].row, directed_q[i].col,
                          directed_q[i].val, directed_q[i].checked, directed_q[i].want);
        end
        while (items_sent < ITEM_TARGET)
            run_phase(phases == 0);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d commands over %0d search phases (%0d wide), %0d register writes",
                 items_sent, phases, wide_phases, reg_writes);
        $display("Checked %0d results: %0d partitions, %0d exhaustion reports, %0d long holds",
                 results_seen, partitions_seen, exhaust_seen, hold_requests);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
